### sv/assert_macros.svh
// Assertion macros used by the checker file of the nearest-codeword histogram core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the cycle after ante; drop the check while reset is active.
`define NCH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("nch: next-cycle check failed");

// Check cons in the cycle after ante, reset included (for reset behavior itself).
`define NCH_ASSERT_NEXT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("nch: reset check failed");

`endif

### sv/nch_pkg.sv
// Shared types, constants and helper function of the nearest-codeword histogram core.
package nch_pkg;

    localparam int COORD_W    = 16;
    localparam int IDX_W      = 6;
    localparam int HIT_W      = 16;
    localparam int DIST_W     = 35;
    localparam int REQ_W      = 2;
    localparam int IN_USE_W   = 7;
    localparam int N_IN_COORD = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 64;

    localparam logic [IN_USE_W-1:0] IN_USE_RESET = 7'd64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_USE    = 3'd4;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_READ,
        ST_READ_WAIT,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    // Control tag that travels with each codeword through the distance pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } scan_tag_t;

    // Add two Q8.8 values, clamp to the signed 16-bit range
    function automatic coord_t sat_add16(coord_t a, coord_t b);
        logic [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1]) begin
            sat_add16 = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            sat_add16 = s[COORD_W-1:0];
        end
    endfunction

endpackage

### sv/nch_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module nch_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/nch_dist.sv
// Distance pipeline: squared Euclidean distance per codeword and running minimum.
module nch_dist #(
    parameter int DIMENSIONS = 4,
    parameter int AW         = 6
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  nch_pkg::scan_tag_t                      tag_in,
    input  logic [AW-1:0]                           idx_in,
    input  logic [DIMENSIONS*nch_pkg::COORD_W-1:0]  x_in,
    input  logic [DIMENSIONS*nch_pkg::COORD_W-1:0]  cw_in,
    output logic                                    done,
    output logic [AW-1:0]                           best_idx,
    output logic [nch_pkg::DIST_W-1:0]              best_dist
);

    localparam int CW  = nch_pkg::COORD_W;
    localparam int SQW = 2 * CW;
    localparam int DW  = nch_pkg::DIST_W;

    nch_pkg::scan_tag_t tag0_reg, tag1_reg, tag2_reg;
    logic [AW-1:0]      idx0_reg, idx1_reg, idx2_reg;
    logic [CW:0]        diff  [DIMENSIONS];
    logic [CW-1:0]      mag   [DIMENSIONS];
    logic [SQW-1:0]     sq_next [DIMENSIONS];
    logic [SQW-1:0]     sq_reg  [DIMENSIONS];
    logic [DW-1:0]      sum_next, sum_reg;
    logic [DW-1:0]      best_dist_reg;
    logic [AW-1:0]      best_idx_reg;
    logic               done_reg;

    // One multiplier per lane; the RAM output register is the stage before
    for (genvar d = 0; d < DIMENSIONS; d++) begin : g_lane
        assign diff[d] = {x_in[d*CW+CW-1], x_in[d*CW +: CW]}
                       - {cw_in[d*CW+CW-1], cw_in[d*CW +: CW]};
        assign mag[d]  = diff[d][CW] ? CW'(-diff[d]) : diff[d][CW-1:0];
        assign sq_next[d] = SQW'(mag[d]) * SQW'(mag[d]);

        always_ff @(posedge aclk) begin
            sq_reg[d] <= sq_next[d];
        end
    end

    // Up to eight squares of at most (2^16-1)^2 each stay below 2^35, so no clamp
    always_comb begin
        sum_next = '0;
        for (int d = 0; d < DIMENSIONS; d++) begin
            sum_next = sum_next + DW'(sq_reg[d]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag0_reg <= '0;
            tag1_reg <= '0;
            tag2_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            tag0_reg <= tag_in;
            tag1_reg <= tag0_reg;
            tag2_reg <= tag1_reg;
            done_reg <= tag2_reg.valid && tag2_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        idx0_reg <= idx_in;
        idx1_reg <= idx0_reg;
        idx2_reg <= idx1_reg;
        sum_reg  <= sum_next;
        // Keep the earlier index on a tie: replace only on strictly smaller
        if (tag2_reg.valid && (tag2_reg.first || (sum_reg < best_dist_reg))) begin
            best_dist_reg <= sum_reg;
            best_idx_reg  <= idx2_reg;
        end
    end

    assign done      = done_reg;
    assign best_idx  = best_idx_reg;
    assign best_dist = best_dist_reg;

endmodule

### sv/nearest_codeword_histogram_core.sv
// Top level of the nearest-codeword histogram core: sequencer, registers and memories.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready with the request kind on s_tuser and
//   the index and four Q8.8 coordinates on s_tdata. Each beat yields exactly one
//   result beat on m_tvalid/m_tready. Configuration writes go over cfg_valid/
//   cfg_ready (always ready); the user must make them only while the core is idle;
//   the core does not enforce this. Steps from input beat to result beat:
//     load codeword: LOAD, then RESULT; read count: READ, READ_WAIT, RESULT
//     query: SCAN over the n codewords searched, DRAIN, UPDATE, RESULT; the
//       codebook RAM delivers one codeword per cycle, so n sets how long SCAN runs
//     clear counts: CLEAR zeroes one counter per cycle over every entry, then RESULT
//   The core works on one item at a time; the next beat is taken once the
//   current item has placed its result in the output register.
//   Reset (aresetn low, synchronous) clears the control and configuration registers
//   and starts a pass that zeroes the counter RAM; s_tready stays low until
//   it ends. The codebook RAM is not cleared: load every entry before a query
//   searches it. A stalled receiver holds the result beat in the output
//   register; the core still accepts one more item and finishes its work, then
//   waits with that result until the register frees.
module nearest_codeword_histogram_core #(
    parameter int CODEBOOK_DEPTH = 64,
    parameter int DIMENSIONS     = 4,
    parameter int COUNT_WIDTH    = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: [5:0] entry_index, [21:6] coord_a, [37:22] coord_b,
    //          [53:38] coord_c, [69:54] coord_d, [71:70] zero
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nch_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: [1:0] req_type
    input  logic [nch_pkg::REQ_W-1:0]         s_tuser,
    // m_tdata: [5:0] nearest_index, [21:6] hit_count, [56:22] min_distance,
    //          [63:57] zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [nch_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nch_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nch_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW    = $clog2(CODEBOOK_DEPTH);
    localparam int IDXW  = nch_pkg::IDX_W;
    localparam int HITW  = nch_pkg::HIT_W;
    localparam int DISTW = nch_pkg::DIST_W;
    localparam int CW    = nch_pkg::COORD_W;
    localparam int NIN   = nch_pkg::N_IN_COORD;
    localparam int UW    = nch_pkg::IN_USE_W;
    localparam int IW    = (AW > IDXW) ? AW : IDXW;
    localparam int NW    = ((AW + 1) > UW) ? (AW + 1) : UW;
    localparam int CB_W  = DIMENSIONS * CW;
    localparam int PADW  = nch_pkg::M_TDATA_W - DISTW - HITW - IDXW;

    nch_pkg::state_t    state_reg, state_next;

    nch_pkg::coord_t    center_reg [NIN];
    logic [UW-1:0]      in_use_reg;

    nch_pkg::coord_t    s_coord   [NIN];
    nch_pkg::coord_t    coord_reg [NIN];
    logic [IDXW-1:0]    s_idx;
    nch_pkg::req_t      s_req;
    logic               s_fire;

    logic [IDXW-1:0]    idx_reg;
    logic [CB_W-1:0]    x_next, x_reg;
    logic [AW-1:0]      last_next, last_reg;
    logic [NW-1:0]      n_raw, n_eff;
    logic [IW-1:0]      idx_wide;
    logic               idx_in_range;
    logic [AW-1:0]      idx_addr;

    logic [AW-1:0]      scan_addr_reg, scan_addr_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic               clr_result_reg, clr_result_next;

    logic [IDXW-1:0]    pend_idx_reg, pend_idx_next;
    logic [HITW-1:0]    pend_cnt_reg, pend_cnt_next;
    logic [DISTW-1:0]   pend_dist_reg, pend_dist_next;

    logic               out_valid_reg, out_valid_next;
    logic [IDXW-1:0]    out_idx_reg, out_idx_next;
    logic [HITW-1:0]    out_cnt_reg, out_cnt_next;
    logic [DISTW-1:0]   out_dist_reg, out_dist_next;
    logic               out_free;

    logic               cb_we;
    logic [CB_W-1:0]    cb_wdata, cb_rdata;
    logic               cnt_we;
    logic [AW-1:0]      cnt_waddr, cnt_raddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata, cnt_inc;

    nch_pkg::scan_tag_t scan_tag;
    logic               dist_done;
    logic [AW-1:0]      best_idx;
    logic [DISTW-1:0]   best_dist;

    // ---------------------------------------------------------------- input
    assign s_idx  = s_tdata[IDXW-1:0];
    assign s_req  = nch_pkg::req_t'(s_tuser);
    assign s_fire = s_tvalid && s_tready;

    for (genvar d = 0; d < NIN; d++) begin : g_in_coord
        assign s_coord[d] = s_tdata[IDXW + d*CW +: CW];
    end

    // Query point and load data per lane; lanes past the carried four are zero
    for (genvar d = 0; d < DIMENSIONS; d++) begin : g_lane
        if (d < NIN) begin : g_live
            assign x_next[d*CW +: CW]   = nch_pkg::sat_add16(center_reg[d], s_coord[d]);
            assign cb_wdata[d*CW +: CW] = coord_reg[d];
        end else begin : g_zero
            assign x_next[d*CW +: CW]   = '0;
            assign cb_wdata[d*CW +: CW] = '0;
        end
    end

    // Clamp the search length to 1..CODEBOOK_DEPTH
    always_comb begin
        n_raw = NW'(in_use_reg);
        if (n_raw == '0) begin
            n_eff = NW'(1);
        end else if (n_raw > NW'(CODEBOOK_DEPTH)) begin
            n_eff = NW'(CODEBOOK_DEPTH);
        end else begin
            n_eff = n_raw;
        end
        last_next = AW'(n_eff - NW'(1));
    end

    assign idx_wide     = IW'(idx_reg);
    assign idx_in_range = ({1'b0, idx_wide} < (IW + 1)'(CODEBOOK_DEPTH));
    assign idx_addr     = idx_wide[AW-1:0];

    assign out_free = !out_valid_reg || m_tready;

    // ---------------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nch_pkg::ST_CLEAR: begin
                if (clr_addr_reg == AW'(CODEBOOK_DEPTH - 1)) begin
                    state_next = clr_result_reg ? nch_pkg::ST_RESULT : nch_pkg::ST_IDLE;
                end
            end
            nch_pkg::ST_IDLE: begin
                if (s_fire) begin
                    case (s_req)
                        nch_pkg::REQ_LOAD:  state_next = nch_pkg::ST_LOAD;
                        nch_pkg::REQ_QUERY: state_next = nch_pkg::ST_SCAN;
                        nch_pkg::REQ_READ:  state_next = nch_pkg::ST_READ;
                        nch_pkg::REQ_CLEAR: state_next = nch_pkg::ST_CLEAR;
                        default:            state_next = nch_pkg::ST_IDLE;
                    endcase
                end
            end
            nch_pkg::ST_LOAD:      state_next = nch_pkg::ST_RESULT;
            nch_pkg::ST_READ:      state_next = nch_pkg::ST_READ_WAIT;
            nch_pkg::ST_READ_WAIT: state_next = nch_pkg::ST_RESULT;
            nch_pkg::ST_SCAN: begin
                if (scan_addr_reg == last_reg) begin
                    state_next = nch_pkg::ST_DRAIN;
                end
            end
            nch_pkg::ST_DRAIN: begin
                if (dist_done) begin
                    state_next = nch_pkg::ST_UPDATE;
                end
            end
            nch_pkg::ST_UPDATE:    state_next = nch_pkg::ST_RESULT;
            nch_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = nch_pkg::ST_IDLE;
                end
            end
            default:               state_next = nch_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- outputs
    // Counter RAM accesses never overlap: the read of the winning counter is issued
    // in the cycle before its write-back, and the next item starts after that.
    assign cnt_inc = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + COUNT_WIDTH'(1);

    always_comb begin
        s_tready       = (state_reg == nch_pkg::ST_IDLE);
        cb_we          = (state_reg == nch_pkg::ST_LOAD) && idx_in_range;
        scan_tag.valid = (state_reg == nch_pkg::ST_SCAN);
        scan_tag.first = (scan_addr_reg == '0);
        scan_tag.last  = (scan_addr_reg == last_reg);
        cnt_raddr      = (state_reg == nch_pkg::ST_READ) ? idx_addr : best_idx;
        cnt_we         = 1'b0;
        cnt_waddr      = best_idx;
        cnt_wdata      = cnt_inc;
        case (state_reg)
            nch_pkg::ST_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_addr_reg;
                cnt_wdata = '0;
            end
            nch_pkg::ST_UPDATE: begin
                cnt_we = 1'b1;
            end
            default: begin
                cnt_we = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- datapath next
    always_comb begin
        scan_addr_next  = scan_addr_reg;
        clr_addr_next   = clr_addr_reg;
        clr_result_next = clr_result_reg;
        pend_idx_next   = pend_idx_reg;
        pend_cnt_next   = pend_cnt_reg;
        pend_dist_next  = pend_dist_reg;
        out_valid_next  = out_valid_reg;
        out_idx_next    = out_idx_reg;
        out_cnt_next    = out_cnt_reg;
        out_dist_next   = out_dist_reg;

        // Echo the index with zero count and distance unless overwritten below
        if (s_fire) begin
            scan_addr_next  = '0;
            clr_result_next = (s_req == nch_pkg::REQ_CLEAR);
            pend_idx_next   = s_idx;
            pend_cnt_next   = '0;
            pend_dist_next  = '0;
        end

        case (state_reg)
            nch_pkg::ST_CLEAR: begin
                clr_addr_next = (clr_addr_reg == AW'(CODEBOOK_DEPTH - 1)) ?
                                '0 : clr_addr_reg + AW'(1);
            end
            nch_pkg::ST_SCAN: begin
                scan_addr_next = scan_addr_reg + AW'(1);
            end
            nch_pkg::ST_READ_WAIT: begin
                pend_cnt_next = idx_in_range ? HITW'(cnt_rdata) : '0;
            end
            nch_pkg::ST_UPDATE: begin
                pend_idx_next  = IDXW'(best_idx);
                pend_cnt_next  = HITW'(cnt_inc);
                pend_dist_next = best_dist;
            end
            default: begin
            end
        endcase

        // Output register: drop a taken beat, load the finished result
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == nch_pkg::ST_RESULT) && out_free) begin
            out_valid_next = 1'b1;
            out_idx_next   = pend_idx_reg;
            out_cnt_next   = pend_cnt_reg;
            out_dist_next  = pend_dist_reg;
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= nch_pkg::ST_CLEAR;
            clr_addr_reg   <= '0;
            clr_result_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            scan_addr_reg  <= '0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            clr_result_reg <= clr_result_next;
            out_valid_reg  <= out_valid_next;
            scan_addr_reg  <= scan_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg  <= pend_idx_next;
        pend_cnt_reg  <= pend_cnt_next;
        pend_dist_reg <= pend_dist_next;
        out_idx_reg   <= out_idx_next;
        out_cnt_reg   <= out_cnt_next;
        out_dist_reg  <= out_dist_next;
        if (s_fire) begin
            idx_reg  <= s_idx;
            x_reg    <= x_next;
            last_reg <= last_next;
            for (int d = 0; d < NIN; d++) begin
                coord_reg[d] <= s_coord[d];
            end
        end
    end

    // Configuration registers; writes beyond the list are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < NIN; d++) begin
                center_reg[d] <= '0;
            end
            in_use_reg <= nch_pkg::IN_USE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                nch_pkg::CFG_CENTER_X0: center_reg[0] <= cfg_data;
                nch_pkg::CFG_CENTER_X1: center_reg[1] <= cfg_data;
                nch_pkg::CFG_CENTER_X2: center_reg[2] <= cfg_data;
                nch_pkg::CFG_CENTER_X3: center_reg[3] <= cfg_data;
                nch_pkg::CFG_IN_USE:    in_use_reg    <= cfg_data[UW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{PADW{1'b0}}, out_dist_reg, out_cnt_reg, out_idx_reg};

    // ---------------------------------------------------------------- memories
    nch_ram #(
        .WIDTH (CB_W),
        .DEPTH (CODEBOOK_DEPTH)
    ) u_codebook (
        .aclk  (aclk),
        .we    (cb_we),
        .waddr (idx_addr),
        .wdata (cb_wdata),
        .raddr (scan_addr_reg),
        .rdata (cb_rdata)
    );

    nch_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (CODEBOOK_DEPTH)
    ) u_counts (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    nch_dist #(
        .DIMENSIONS (DIMENSIONS),
        .AW         (AW)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tag_in    (scan_tag),
        .idx_in    (scan_addr_reg),
        .x_in      (x_reg),
        .cw_in     (cb_rdata),
        .done      (dist_done),
        .best_idx  (best_idx),
        .best_dist (best_dist)
    );

endmodule

### sv/nch_checker.sv
// Port-level checker for the nearest-codeword histogram core, bound to the top level.
`include "assert_macros.svh"

module nch_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [nch_pkg::M_TDATA_W-1:0] m_tdata
);

    // Hold a stalled result beat unchanged
    `NCH_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // One item at a time: drop ready right after an input beat
    `NCH_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // Reset starts the counter clearing pass, so no beat is taken right after it
    `NCH_ASSERT_NEXT_RST(a_rst_busy, aclk, !aresetn, !s_tready)

    // Reset empties the output register
    `NCH_ASSERT_NEXT_RST(a_rst_out, aclk, !aresetn, !m_tvalid)

endmodule

bind nearest_codeword_histogram_core nch_checker u_nch_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/nearest_codeword_histogram_core_tb.sv
// Self-checking testbench for the nearest-codeword histogram core with a built-in predictor.
`timescale 1ns / 1ps

module nearest_codeword_histogram_core_tb;

    localparam int               CB_DEPTH    = 64;
    localparam int               CYCLE_LIMIT = 500_000;
    localparam longint           DIST_SAT    = 64'h7_FFFF_FFFF;
    localparam nch_pkg::coord_t  C_MAX       = 16'sh7FFF;
    localparam nch_pkg::coord_t  C_MIN       = -16'sh8000;

    typedef struct packed {
        nch_pkg::req_t                                 req;
        logic [nch_pkg::IDX_W-1:0]                     idx;
        nch_pkg::coord_t [nch_pkg::N_IN_COORD-1:0]     crd;
    } shock_req_t;

    typedef struct packed {
        logic [nch_pkg::IDX_W-1:0]  idx;
        logic [nch_pkg::HIT_W-1:0]  hits;
        logic [nch_pkg::DIST_W-1:0] sq_dist;
    } bin_result_t;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [nch_pkg::S_TDATA_W-1:0]     s_tdata   = '0;
    logic [nch_pkg::REQ_W-1:0]         s_tuser   = '0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [nch_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [nch_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [nch_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;

    nearest_codeword_histogram_core #(
        .CODEBOOK_DEPTH(CB_DEPTH),
        .DIMENSIONS    (4),
        .COUNT_WIDTH   (16)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Predictor state: codebook, hit counters and the programmed operating point
    nch_pkg::coord_t [nch_pkg::N_IN_COORD-1:0] cb_coord [CB_DEPTH];
    logic [nch_pkg::HIT_W-1:0]                 hit_tally [CB_DEPTH];
    nch_pkg::coord_t                           center_pt [nch_pkg::N_IN_COORD];
    logic [nch_pkg::IN_USE_W-1:0]              search_len = nch_pkg::IN_USE_RESET;

    // Stimulus-side copy of the codebook, used to aim queries near a codeword
    nch_pkg::coord_t [nch_pkg::N_IN_COORD-1:0] cw_gen [CB_DEPTH];

    shock_req_t   pending_beats [$];
    bin_result_t  expected_bins [$];
    int           items_issued = 0;
    int           items_taken  = 0;
    int           fail_count   = 0;
    int           cycle_count  = 0;
    int           s_idle_max   = 5;
    int           m_idle_max   = 5;
    logic         s_took       = 1'b0;
    logic         m_took       = 1'b0;

    function automatic nch_pkg::coord_t clamp16(input int v);
        if (v > 32767) return C_MAX;
        if (v < -32768) return C_MIN;
        return nch_pkg::coord_t'(v);
    endfunction

    // Apply one request to the predictor state and return the result beat it yields
    function automatic bin_result_t histogram_apply(input shock_req_t it);
        bin_result_t     r;
        nch_pkg::coord_t x [nch_pkg::N_IN_COORD];
        int              span, best, k, d;
        longint          acc, df, bestd;
        r.idx     = it.idx;
        r.hits    = '0;
        r.sq_dist = '0;
        best      = 0;
        bestd     = 0;
        case (it.req)
            nch_pkg::REQ_LOAD: begin
                cb_coord[it.idx] = it.crd;
            end
            nch_pkg::REQ_QUERY: begin
                span = int'(search_len);
                if (span == 0) span = 1;
                if (span > CB_DEPTH) span = CB_DEPTH;
                // shifted point, clamped per coordinate
                for (d = 0; d < nch_pkg::N_IN_COORD; d++)
                    x[d] = clamp16(int'(center_pt[d]) + int'($signed(it.crd[d])));
                for (k = 0; k < span; k++) begin
                    acc = 0;
                    for (d = 0; d < nch_pkg::N_IN_COORD; d++) begin
                        df  = longint'(x[d]) - longint'($signed(cb_coord[k][d]));
                        acc += df * df;
                    end
                    if (acc > DIST_SAT) acc = DIST_SAT;
                    // strict compare keeps the lowest index on a tie
                    if (k == 0 || acc < bestd) begin
                        bestd = acc;
                        best  = k;
                    end
                end
                if (hit_tally[best] != {nch_pkg::HIT_W{1'b1}}) hit_tally[best]++;
                r.idx     = best[nch_pkg::IDX_W-1:0];
                r.hits    = hit_tally[best];
                r.sq_dist = bestd[nch_pkg::DIST_W-1:0];
            end
            nch_pkg::REQ_READ: begin
                r.hits = hit_tally[it.idx];
            end
            nch_pkg::REQ_CLEAR: begin
                for (k = 0; k < CB_DEPTH; k++) hit_tally[k] = '0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Sample both streams at the rising edge: predict on input beats, check output beats
    always @(posedge aclk) begin : monitor
        shock_req_t  beat;
        bin_result_t got, want;
        if (!aresetn) begin
            s_took <= 1'b0;
            m_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            m_took <= m_tvalid && m_tready;
            if (s_tvalid && s_tready) begin
                beat.req = nch_pkg::req_t'(s_tuser);
                beat.idx = s_tdata[5:0];
                beat.crd = s_tdata[69:6];
                expected_bins.push_back(histogram_apply(beat));
                items_taken++;
            end
            if (m_tvalid && m_tready) begin
                got.idx     = m_tdata[5:0];
                got.hits    = m_tdata[21:6];
                got.sq_dist = m_tdata[56:22];
                if (expected_bins.size() == 0) begin
                    note_failure($sformatf(
                        "result beat with nothing pending: idx %0d hits %0d dist %0d",
                        got.idx, got.hits, got.sq_dist));
                end else begin
                    want = expected_bins.pop_front();
                    if (got.idx != want.idx || got.hits != want.hits ||
                        got.sq_dist != want.sq_dist)
                        note_failure($sformatf(
                            "exp idx %0d hits %0d dist %0d, got idx %0d hits %0d dist %0d",
                            want.idx, want.hits, want.sq_dist,
                            got.idx, got.hits, got.sq_dist));
                end
            end
        end
    end

    // Input side: hold a beat until taken, then idle for the drawn gap
    always @(negedge aclk) begin : shock_driver
        shock_req_t it;
        int         s_gap;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap = 0;
        end else if (s_tvalid && !s_took) begin
            // hold the current beat
        end else if (s_gap > 0) begin
            s_gap--;
            s_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
            it = pending_beats.pop_front();
            s_tdata  <= {2'b00, it.crd, it.idx};
            s_tuser  <= it.req;
            s_tvalid <= 1'b1;
            s_gap = $urandom_range(0, s_idle_max);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Output side: after each result beat, stall for a drawn number of cycles
    always @(negedge aclk) begin : result_sink
        int m_gap;
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap = 0;
        end else begin
            if (m_took) m_gap = $urandom_range(0, m_idle_max);
            if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_item(input nch_pkg::req_t req, input logic [nch_pkg::IDX_W-1:0] idx,
                             input nch_pkg::coord_t a, input nch_pkg::coord_t b,
                             input nch_pkg::coord_t c, input nch_pkg::coord_t d);
        shock_req_t it;
        it.req = req;
        it.idx = idx;
        it.crd = {d, c, b, a};
        if (req == nch_pkg::REQ_LOAD) cw_gen[idx] = it.crd;
        pending_beats.push_back(it);
        items_issued++;
    endtask

    task automatic cfg_write(input logic [nch_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nch_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            nch_pkg::CFG_CENTER_X0: center_pt[0] = nch_pkg::coord_t'(val);
            nch_pkg::CFG_CENTER_X1: center_pt[1] = nch_pkg::coord_t'(val);
            nch_pkg::CFG_CENTER_X2: center_pt[2] = nch_pkg::coord_t'(val);
            nch_pkg::CFG_CENTER_X3: center_pt[3] = nch_pkg::coord_t'(val);
            nch_pkg::CFG_IN_USE:    search_len   = val[nch_pkg::IN_USE_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_operating_point(input nch_pkg::coord_t c0, input nch_pkg::coord_t c1,
                                       input nch_pkg::coord_t c2, input nch_pkg::coord_t c3,
                                       input logic [nch_pkg::IN_USE_W-1:0] len);
        cfg_write(nch_pkg::CFG_CENTER_X0, c0);
        cfg_write(nch_pkg::CFG_CENTER_X1, c1);
        cfg_write(nch_pkg::CFG_CENTER_X2, c2);
        cfg_write(nch_pkg::CFG_CENTER_X3, c3);
        cfg_write(nch_pkg::CFG_IN_USE,
                  {{(nch_pkg::CFG_DATA_W-nch_pkg::IN_USE_W){1'b0}}, len});
    endtask

    // Block until every queued beat was taken and every result has come back
    task automatic wait_drained();
        while (items_taken != items_issued || expected_bins.size() != 0) @(negedge aclk);
    endtask

    // One random request; queries mostly land near a codeword inside the searched range
    task automatic random_item();
        int              pick, span, k, d, j;
        nch_pkg::coord_t v [nch_pkg::N_IN_COORD];
        span = int'(search_len);
        if (span == 0) span = 1;
        if (span > CB_DEPTH) span = CB_DEPTH;
        pick = $urandom_range(0, 99);
        for (d = 0; d < nch_pkg::N_IN_COORD; d++) v[d] = nch_pkg::coord_t'($urandom);
        if (pick < 40) begin
            if ($urandom_range(0, 2) != 0) begin
                k = $urandom_range(0, span - 1);
                for (d = 0; d < nch_pkg::N_IN_COORD; d++)
                    v[d] = clamp16(int'($signed(cw_gen[k][d])) - int'(center_pt[d])
                                   + $urandom_range(0, 128) - 64);
            end
            push_item(nch_pkg::REQ_QUERY, nch_pkg::IDX_W'($urandom), v[0], v[1], v[2], v[3]);
        end else if (pick < 65) begin
            // sometimes duplicate another entry so that ties occur
            if ($urandom_range(0, 3) == 0) begin
                j = $urandom_range(0, CB_DEPTH - 1);
                for (d = 0; d < nch_pkg::N_IN_COORD; d++) v[d] = cw_gen[j][d];
            end
            push_item(nch_pkg::REQ_LOAD, nch_pkg::IDX_W'($urandom), v[0], v[1], v[2], v[3]);
        end else if (pick < 94) begin
            push_item(nch_pkg::REQ_READ, nch_pkg::IDX_W'($urandom), v[0], v[1], v[2], v[3]);
        end else begin
            push_item(nch_pkg::REQ_CLEAR, nch_pkg::IDX_W'($urandom), v[0], v[1], v[2], v[3]);
        end
    endtask

    initial begin : stimulus
        logic [nch_pkg::IN_USE_W-1:0] span_plan [8];
        nch_pkg::coord_t              c [nch_pkg::N_IN_COORD];
        int                           p, i, d;
        span_plan = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd33, 7'd64, 7'd65, 7'd2};
        for (i = 0; i < CB_DEPTH; i++) begin
            hit_tally[i] = '0;
            cb_coord[i]  = '0;
            cw_gen[i]    = '0;
        end
        for (d = 0; d < nch_pkg::N_IN_COORD; d++) center_pt[d] = '0;

        // synchronous reset, released on a falling edge
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset values: counters zero, full search, center at origin
        push_item(nch_pkg::REQ_READ,  6'd0,  0, 0, 0, 0);
        push_item(nch_pkg::REQ_READ,  6'd63, 0, 0, 0, 0);
        push_item(nch_pkg::REQ_CLEAR, 6'd37, 0, 0, 0, 0);
        push_item(nch_pkg::REQ_LOAD,  6'd0,  C_MIN, C_MIN, C_MIN, C_MIN);
        push_item(nch_pkg::REQ_LOAD,  6'd63, C_MAX, C_MAX, C_MAX, C_MAX);
        push_item(nch_pkg::REQ_LOAD,  6'd1,  0, 0, 0, 0);
        push_item(nch_pkg::REQ_LOAD,  6'd2,  0, 0, 0, 0);
        push_item(nch_pkg::REQ_LOAD,  6'd3,  16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
        push_item(nch_pkg::REQ_READ,  6'd63, 0, 0, 0, 0);
        wait_drained();

        // zero in use acts as one entry; center at the top so shocks clamp high
        set_operating_point(C_MAX, C_MAX, C_MAX, C_MAX, 7'd0);
        push_item(nch_pkg::REQ_QUERY, 6'd21, C_MAX, C_MAX, C_MAX, C_MAX);
        push_item(nch_pkg::REQ_QUERY, 6'd42, C_MIN, C_MIN, C_MIN, C_MIN);
        push_item(nch_pkg::REQ_QUERY, 6'd63, 16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555);
        push_item(nch_pkg::REQ_READ,  6'd0,  0, 0, 0, 0);
        wait_drained();

        // four entries, center at the bottom: clamp low, exact hit, tie between 1 and 2
        set_operating_point(C_MIN, C_MIN, C_MIN, C_MIN, 7'd4);
        push_item(nch_pkg::REQ_QUERY, 6'd0,  C_MIN, C_MIN, C_MIN, C_MIN);
        push_item(nch_pkg::REQ_QUERY, 6'd5,  C_MAX, C_MAX, C_MAX, C_MAX);
        push_item(nch_pkg::REQ_QUERY, 6'd9,  C_MAX, C_MAX, C_MAX, C_MAX);
        push_item(nch_pkg::REQ_READ,  6'd1,  0, 0, 0, 0);
        push_item(nch_pkg::REQ_CLEAR, 6'd2,  0, 0, 0, 0);
        push_item(nch_pkg::REQ_READ,  6'd1,  0, 0, 0, 0);
        push_item(nch_pkg::REQ_READ,  6'd0,  0, 0, 0, 0);
        wait_drained();

        for (p = 0; p < 8; p++) begin
            s_idle_max = (p % 4 == 0 || p % 4 == 3) ? 5 : 0;
            m_idle_max = (p % 4 == 0 || p % 4 == 2) ? 5 : 0;
            for (d = 0; d < nch_pkg::N_IN_COORD; d++) begin
                if (p == 0) c[d] = '0;
                else if (p == 6) c[d] = nch_pkg::coord_t'($urandom);
                else c[d] = nch_pkg::coord_t'($urandom_range(0, 4095) - 2048);
            end
            if (p == 3) begin
                c[0] = C_MAX;
                c[1] = C_MIN;
                c[2] = C_MIN;
                c[3] = C_MAX;
            end
            set_operating_point(c[0], c[1], c[2], c[3],
                                (p == 5) ? nch_pkg::IN_USE_W'($urandom_range(1, 64))
                                         : span_plan[p]);
            if (p == 0) begin
                // fill the whole codebook before any wide search
                for (i = 0; i < CB_DEPTH; i++) begin
                    if (i % 8 == 7)
                        push_item(nch_pkg::REQ_LOAD, i[nch_pkg::IDX_W-1:0],
                                  cw_gen[i-3][0], cw_gen[i-3][1],
                                  cw_gen[i-3][2], cw_gen[i-3][3]);
                    else
                        push_item(nch_pkg::REQ_LOAD, i[nch_pkg::IDX_W-1:0],
                                  nch_pkg::coord_t'($urandom), nch_pkg::coord_t'($urandom),
                                  nch_pkg::coord_t'($urandom), nch_pkg::coord_t'($urandom));
                end
            end
            repeat (130) random_item();
            wait_drained();
        end

        // hammer one counter at full rate
        s_idle_max = 0;
        m_idle_max = 0;
        set_operating_point(0, 0, 0, 0, 7'd1);
        push_item(nch_pkg::REQ_CLEAR, 6'd0, 0, 0, 0, 0);
        repeat (20)
            push_item(nch_pkg::REQ_QUERY, nch_pkg::IDX_W'($urandom),
                      nch_pkg::coord_t'($urandom), nch_pkg::coord_t'($urandom),
                      nch_pkg::coord_t'($urandom), nch_pkg::coord_t'($urandom));
        push_item(nch_pkg::REQ_READ,  6'd0, 0, 0, 0, 0);
        push_item(nch_pkg::REQ_CLEAR, 6'd0, 0, 0, 0, 0);
        push_item(nch_pkg::REQ_READ,  6'd0, 0, 0, 0, 0);
        wait_drained();

        // let a stray late beat show up before the verdict
        repeat (CB_DEPTH + 8) @(posedge aclk);
        if (expected_bins.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_bins.size()));
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
